// ===== hdl/bf4d_pkg.sv =====
// Shared constants, widths, types and helper functions of the four-axis box fold.
package bf4d_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = COORD_BITS - 8;
  localparam int NUM_AXES   = 4;
  localparam int NUM_MULT   = 5;
  localparam int CFG_W      = 64;

  localparam int QUO_W      = 13;
  localparam int DIV_STAGES = QUO_W;
  localparam int DEN_W      = 21;
  localparam int NUM_W      = 34;

  localparam int LIM_W = 21;
  localparam int LSH   = FRAC_BITS - 12;
  localparam int LSH_L = (LSH > 0) ? LSH : 0;
  localparam int LSH_R = (LSH < 0) ? -LSH : 0;
  localparam int LC_W  = LIM_W + LSH_L;
  localparam int FW    = ((COORD_BITS > LC_W) ? COORD_BITS : LC_W) + 3;

  localparam int DSH   = FRAC_BITS - 16;
  localparam int DSH_L = (DSH > 0) ? 0 : -DSH;
  localparam int DSH_R = (DSH > 0) ? DSH : 0;
  localparam int DW    = FW + 1 - DSH_R + DSH_L;
  localparam int TW    = 16 + DW + 1 - 12;
  localparam int CSW   = ((TW > 32) ? TW : 32) + 4;

  localparam int LANE_LAT  = DIV_STAGES + 7;
  localparam int MERGE_LAT = NUM_MULT + 1;
  localparam int PIPE_LAT  = 1 + LANE_LAT + MERGE_LAT;

  localparam int FLAG_PROG     = 0;
  localparam int FLAG_AXIS     = 1;
  localparam int FLAG_COLOUR   = 5;
  localparam int FLAG_WEIGHTED = 6;
  localparam int FLAG_MULT     = 7;

  typedef enum logic [2:0] {
    REG_FOLD_LIMITS,
    REG_MODE_FLAGS,
    REG_SHRINK_RATES,
    REG_SHRINK_SCALES,
    REG_START_ITERS,
    REG_STOP_ITERS,
    REG_MULT_SCALES,
    REG_COLOUR_FACTORS
  } reg_idx_t;

  typedef struct packed {
    logic        prog;
    logic        fold_en;
    logic        weighted;
    logic [15:0] limit;
    logic [15:0] rate;
    logic [15:0] scale;
    logic [7:0]  start;
    logic [15:0] factor;
  } lane_cfg_t;

  typedef struct packed {
    logic                     colour_on;
    logic [NUM_MULT-1:0]      mult_en;
    logic [NUM_MULT*8-1:0]    starts;
    logic [NUM_MULT*8-1:0]    stops;
    logic [NUM_MULT*12-1:0]   scales;
  } merge_cfg_t;

  // Converts a Q.12 limit to the fraction of the point format, rounding half up when it narrows.
  function automatic logic signed [LC_W-1:0] conv_lim(input logic signed [LIM_W-1:0] v);
    logic signed [LIM_W:0] vext;
    logic signed [LIM_W:0] half;
    logic signed [LIM_W:0] r;
    logic signed [LC_W-1:0] res;
    vext = (LIM_W+1)'(v);
    half = (LSH_R > 0) ? ((LIM_W+1)'(1) <<< ((LSH_R > 0) ? LSH_R - 1 : 0)) : '0;
    r = (vext + half) >>> LSH_R;
    if (LSH_R > 0) begin
      res = LC_W'(r);
    end else begin
      res = LC_W'(v) <<< LSH_L;
    end
    return res;
  endfunction

endpackage

// ===== hdl/box_fold_4d.sv =====
// Top level of the four-axis box fold: configuration registers, lanes and merge.
//
//  Channel  Handshake        Payload
//  input    start / busy     z_x z_y z_z z_w iteration colour_in distance_in
//  result   done (strobe)    fold_x fold_y fold_z fold_w colour_out distance_out
//  config   cfg_we           cfg_index cfg_data
//
// One item is taken every cycle; its result passes through the input registers,
// the 13-stage shrink divider in each lane, the limit multiplies, the fold and colour
// stages and one stage per multiplier.
// Reset clears the pipeline and loads the register defaults; busy is high during reset only.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module box_fold_4d import bf4d_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic signed [COORD_BITS-1:0]  z_x,
  input  logic signed [COORD_BITS-1:0]  z_y,
  input  logic signed [COORD_BITS-1:0]  z_z,
  input  logic signed [COORD_BITS-1:0]  z_w,
  input  logic [7:0]                    iteration,
  input  logic signed [31:0]            colour_in,
  input  logic [31:0]                   distance_in,
  output logic signed [COORD_BITS-1:0]  fold_x,
  output logic signed [COORD_BITS-1:0]  fold_y,
  output logic signed [COORD_BITS-1:0]  fold_z,
  output logic signed [COORD_BITS-1:0]  fold_w,
  output logic signed [31:0]            colour_out,
  output logic [31:0]                   distance_out
);

  typedef struct packed {
    logic [31:0] col;
    logic [31:0] de;
    logic [7:0]  it;
  } side_t;

  logic [63:0] fold_limits;
  logic [11:0] mode_flags;
  logic [63:0] shrink_rates;
  logic [63:0] shrink_scales;
  logic [47:0] start_iterations;
  logic [39:0] stop_iterations;
  logic [59:0] multiplier_scales;
  logic [63:0] colour_factors;

  logic [PIPE_LAT-1:0]          vld;
  logic signed [COORD_BITS-1:0] in_z [NUM_AXES];
  logic [7:0]                   in_it;
  logic [31:0]                  in_col;
  logic [31:0]                  in_de;
  side_t                        side [LANE_LAT];

  logic signed [COORD_BITS-1:0] lane_zf [NUM_AXES];
  logic signed [TW-1:0]         lane_term [NUM_AXES];
  logic signed [COORD_BITS-1:0] z_out [NUM_AXES];
  merge_cfg_t                   mcfg;

  assign busy = rst;
  assign done = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_limits       <= 64'h1000100010001000;
      mode_flags        <= '0;
      shrink_rates      <= '0;
      shrink_scales     <= 64'h1000100010001000;
      start_iterations  <= '0;
      stop_iterations   <= '0;
      multiplier_scales <= 60'h100100100100100;
      colour_factors    <= '0;
      vld               <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start & ~busy};
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FOLD_LIMITS:    fold_limits       <= cfg_data;
          REG_MODE_FLAGS:     mode_flags        <= cfg_data[11:0];
          REG_SHRINK_RATES:   shrink_rates      <= cfg_data;
          REG_SHRINK_SCALES:  shrink_scales     <= cfg_data;
          REG_START_ITERS:    start_iterations  <= cfg_data[47:0];
          REG_STOP_ITERS:     stop_iterations   <= cfg_data[39:0];
          REG_MULT_SCALES:    multiplier_scales <= cfg_data[59:0];
          REG_COLOUR_FACTORS: colour_factors    <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_z[0] <= z_x;
    in_z[1] <= z_y;
    in_z[2] <= z_z;
    in_z[3] <= z_w;
    in_it   <= iteration;
    in_col  <= colour_in;
    in_de   <= distance_in;
    side[0] <= '{col: in_col, de: in_de, it: in_it};
    for (int i = 1; i < LANE_LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    lane_cfg_t lcfg;
    assign lcfg = '{
      prog:     mode_flags[FLAG_PROG],
      fold_en:  !mode_flags[FLAG_PROG] || mode_flags[FLAG_AXIS + a],
      weighted: mode_flags[FLAG_WEIGHTED],
      limit:    fold_limits[a*16 +: 16],
      rate:     shrink_rates[a*16 +: 16],
      scale:    shrink_scales[a*16 +: 16],
      start:    start_iterations[a*8 +: 8],
      factor:   colour_factors[a*16 +: 16]
    };
    bf4d_lane u_lane (
      .clk  (clk),
      .cfg  (lcfg),
      .z    (in_z[a]),
      .it   (in_it),
      .zf   (lane_zf[a]),
      .term (lane_term[a])
    );
  end

  assign mcfg = '{
    colour_on: mode_flags[FLAG_COLOUR],
    mult_en:   mode_flags[FLAG_MULT +: NUM_MULT],
    starts:    start_iterations[47:8],
    stops:     stop_iterations,
    scales:    multiplier_scales
  };

  bf4d_merge u_merge (
    .clk          (clk),
    .cfg          (mcfg),
    .zf           (lane_zf),
    .term         (lane_term),
    .colour_in    (signed'(side[LANE_LAT-1].col)),
    .distance_in  (side[LANE_LAT-1].de),
    .it           (side[LANE_LAT-1].it),
    .z_out        (z_out),
    .colour_out   (colour_out),
    .distance_out (distance_out)
  );

  assign fold_x = z_out[0];
  assign fold_y = z_out[1];
  assign fold_z = z_out[2];
  assign fold_w = z_out[3];

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("An accepted item did not produce its result on time.");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("A result appeared without an accepted item.");
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("A result appeared straight after reset.");
`endif

endmodule

// ===== hdl/bf4d_lane.sv =====
// One axis lane: limit shrink divider, limit scaling, box fold and colour term.
module bf4d_lane import bf4d_pkg::*; (
  input  logic                          clk,
  input  lane_cfg_t                     cfg,
  input  logic signed [COORD_BITS-1:0]  z,
  input  logic [7:0]                    it,
  output logic signed [COORD_BITS-1:0]  zf,
  output logic signed [TW-1:0]          term
);

  typedef struct packed {
    logic [NUM_W-1:0]      rem;
    logic [DEN_W-1:0]      den;
    logic [QUO_W-1:0]      quo;
    logic [COORD_BITS-1:0] z;
    logic                  act;
  } div_t;

  localparam logic signed [46:0] HALF24 = 47'sd1 <<< 23;
  localparam logic signed [FW-1:0] ZMAX =
    {{(FW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [FW-1:0] ZMIN = ~ZMAX;
  localparam logic signed [FW:0] DHALF =
    (DSH_R > 0) ? ((FW+1)'(1) <<< ((DSH_R > 0) ? DSH_R - 1 : 0)) : '0;
  localparam logic signed [16+DW:0] THALF = (17+DW)'(1) <<< 11;

  logic [7:0]       kdiff;
  logic [DEN_W-1:0] kq;
  div_t             dv0;
  div_t             dv [DIV_STAGES];

  always_comb begin
    kdiff   = it - cfg.start;
    kq      = DEN_W'({kdiff, 12'd0});
    dv0.den = DEN_W'(cfg.rate) + kq;
    dv0.rem = NUM_W'({kq, 12'd0}) + NUM_W'(dv0.den >> 1);
    dv0.quo = '0;
    dv0.z   = z;
    dv0.act = cfg.prog & cfg.fold_en & (it > cfg.start);
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    div_t             cur;
    div_t             nxt;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    if (i == 0) begin : g_head
      assign cur = dv0;
    end else begin : g_body
      assign cur = dv[i-1];
    end
    assign dsh = NUM_W'(cur.den) << (QUO_W - 1 - i);
    assign ge  = cur.rem >= dsh;
    always_comb begin
      nxt = cur;
      if (ge) begin
        nxt.rem = cur.rem - dsh;
        nxt.quo = cur.quo | (QUO_W'(1) << (QUO_W - 1 - i));
      end
    end
    always_ff @(posedge clk) begin
      dv[i] <= nxt;
    end
  end

  logic signed [29:0]           p1;
  logic signed [45:0]           p2;
  logic                         act1, act2;
  logic signed [COORD_BITS-1:0] z1, z2, z3, z4, zf5, zf6;
  logic signed [LIM_W-1:0]      lim, lim_raw, lim_n;
  logic signed [46:0]           p2r;
  logic signed [LC_W-1:0]       lc, lc4, lc5;
  logic signed [FW-1:0]         a1, a2, abs1, abs2, res;
  logic signed [COORD_BITS-1:0] zsat;
  logic                         chg5, chg6;
  logic signed [FW-1:0]         azf, az, d0;
  logic signed [FW:0]           dsum, dshr;
  logic signed [DW-1:0]         diff_n, diff;
  logic signed [16+DW-1:0]      prod;
  logic signed [16+DW:0]        prnd;
  logic signed [TW-1:0]         tw_n, tu_n;

  always_comb begin
    lim_raw = LIM_W'(signed'(cfg.limit));
    p2r     = 47'(p2) + HALF24;
    lim_n   = LIM_W'(p2r >>> 24);
    lc      = conv_lim(lim);
    abs1    = a1[FW-1] ? -a1 : a1;
    abs2    = a2[FW-1] ? -a2 : a2;
    res     = abs1 - abs2 - FW'(z4);
    if (res > ZMAX) begin
      zsat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (res < ZMIN) begin
      zsat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      zsat = res[COORD_BITS-1:0];
    end
    azf    = FW'(zf5);
    az     = azf[FW-1] ? -azf : azf;
    d0     = az - FW'(lc5);
    dsum   = (FW+1)'(d0) + DHALF;
    dshr   = dsum >>> DSH_R;
    diff_n = DW'(dshr) <<< DSH_L;
    prod   = signed'(cfg.factor) * diff;
    prnd   = (17+DW)'(prod) + THALF;
    tw_n   = TW'(prnd >>> 12);
    tu_n   = TW'(signed'(cfg.factor)) <<< 4;
  end

  always_ff @(posedge clk) begin
    p1   <= signed'(cfg.limit) * signed'({1'b0, dv[DIV_STAGES-1].quo});
    act1 <= dv[DIV_STAGES-1].act;
    z1   <= dv[DIV_STAGES-1].z;
    p2   <= p1 * signed'(cfg.scale);
    act2 <= act1;
    z2   <= z1;
    lim  <= act2 ? lim_n : lim_raw;
    z3   <= z2;
    a1   <= FW'(z3) + FW'(lc);
    a2   <= FW'(z3) - FW'(lc);
    z4   <= z3;
    lc4  <= lc;
    zf5  <= cfg.fold_en ? zsat : z4;
    chg5 <= cfg.fold_en && (zsat != z4);
    lc5  <= lc4;
    diff <= diff_n;
    zf6  <= zf5;
    chg6 <= chg5;
    zf   <= zf6;
    if (!chg6) begin
      term <= '0;
    end else if (cfg.weighted) begin
      term <= tw_n;
    end else begin
      term <= tu_n;
    end
  end

endmodule

// ===== hdl/bf4d_merge.sv =====
// Merging stage: colour accumulation and the five windowed uniform multipliers.
module bf4d_merge import bf4d_pkg::*; (
  input  logic                          clk,
  input  merge_cfg_t                    cfg,
  input  logic signed [COORD_BITS-1:0]  zf [NUM_AXES],
  input  logic signed [TW-1:0]          term [NUM_AXES],
  input  logic signed [31:0]            colour_in,
  input  logic [31:0]                   distance_in,
  input  logic [7:0]                    it,
  output logic signed [COORD_BITS-1:0]  z_out [NUM_AXES],
  output logic signed [31:0]            colour_out,
  output logic [31:0]                   distance_out
);

  localparam logic signed [CSW-1:0] CMAX = {{(CSW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [CSW-1:0] CMIN = ~CMAX;
  localparam logic signed [COORD_BITS+12:0] MZ_MAX =
    {{14{1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS+12:0] MZ_MIN = ~MZ_MAX;
  localparam logic signed [COORD_BITS+12:0] MHALF = (COORD_BITS+13)'(128);

  logic signed [COORD_BITS-1:0] ch_z [NUM_MULT+1][NUM_AXES];
  logic [31:0]                  ch_de [NUM_MULT+1];
  logic signed [31:0]           ch_col [NUM_MULT+1];
  logic [NUM_MULT-1:0]          ch_en [NUM_MULT+1];

  logic signed [CSW-1:0] csum;
  logic signed [31:0]    col_n;
  logic [NUM_MULT-1:0]   en_n;

  always_comb begin
    csum = CSW'(colour_in);
    for (int a = 0; a < NUM_AXES; a++) begin
      csum = csum + CSW'(term[a]);
    end
    if (!cfg.colour_on) begin
      col_n = colour_in;
    end else if (csum > CMAX) begin
      col_n = 32'sh7FFFFFFF;
    end else if (csum < CMIN) begin
      col_n = 32'sh80000000;
    end else begin
      col_n = csum[31:0];
    end
    for (int m = 0; m < NUM_MULT; m++) begin
      en_n[m] = cfg.mult_en[m] && (it >= cfg.starts[m*8 +: 8]) && (it < cfg.stops[m*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    ch_z[0]   <= zf;
    ch_de[0]  <= distance_in;
    ch_col[0] <= col_n;
    ch_en[0]  <= en_n;
  end

  for (genvar m = 0; m < NUM_MULT; m++) begin : g_mult
    logic signed [11:0]            sc;
    logic [11:0]                   sa;
    logic signed [COORD_BITS+12:0] zr [NUM_AXES];
    logic signed [COORD_BITS+12:0] zt [NUM_AXES];
    logic signed [COORD_BITS-1:0]  zs [NUM_AXES];
    logic [44:0]                   dr;
    logic [31:0]                   ds;

    always_comb begin
      sc = cfg.scales[m*12 +: 12];
      sa = sc[11] ? 12'(-sc) : 12'(sc);
      for (int a = 0; a < NUM_AXES; a++) begin
        zr[a] = (COORD_BITS+13)'(ch_z[m][a]) * (COORD_BITS+13)'(sc) + MHALF;
        zt[a] = zr[a] >>> 8;
        if (zt[a] > MZ_MAX) begin
          zs[a] = {1'b0, {(COORD_BITS-1){1'b1}}};
        end else if (zt[a] < MZ_MIN) begin
          zs[a] = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
          zs[a] = zt[a][COORD_BITS-1:0];
        end
      end
      dr = 45'(ch_de[m]) * 45'(sa) + 45'(128);
      ds = (|dr[44:40]) ? 32'hFFFFFFFF : dr[39:8];
    end

    always_ff @(posedge clk) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ch_z[m+1][a] <= ch_en[m][m] ? zs[a] : ch_z[m][a];
      end
      ch_de[m+1]  <= ch_en[m][m] ? ds : ch_de[m];
      ch_col[m+1] <= ch_col[m];
      ch_en[m+1]  <= ch_en[m];
    end
  end

  assign z_out        = ch_z[NUM_MULT];
  assign colour_out   = ch_col[NUM_MULT];
  assign distance_out = ch_de[NUM_MULT];

endmodule

// ===== test/box_fold_4d_tb.sv =====
// Self-checking testbench of the four-axis box fold: random and directed points against a predictor.
`timescale 1ns / 1ps
module box_fold_4d_tb;
  import bf4d_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] zx, zy, zz, zw;
    logic [7:0]                   iter;
    logic signed [31:0]           colour;
    logic [31:0]                  distance;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] fx, fy, fz, fw;
    logic signed [31:0]           colour;
    logic [31:0]                  distance;
  } folded_t;

  logic clk, rst, start, busy, done, cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic signed [COORD_BITS-1:0] z_x, z_y, z_z, z_w, fold_x, fold_y, fold_z, fold_w;
  logic [7:0] iteration;
  logic signed [31:0] colour_in, colour_out;
  logic [31:0] distance_in, distance_out;

  logic [63:0] regs_shadow [8];
  point_t  pending_points [$];
  folded_t expected_folds [$];
  point_t  in_flight;
  int sender_idle_pct, errors, points_sent, folds_checked, settings_used, quiet_cycles;

  box_fold_4d u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic folded_t fold_point(point_t p);
    folded_t r;
    logic [11:0] flags;
    longint z [4], prev [4], lc [4];
    longint lim, kq, den, ratio, sc, f, col, s;
    longint unsigned de, prod;
    int st, sp, it;
    flags = regs_shadow[REG_MODE_FLAGS][11:0];
    it = int'(p.iter);
    z[0] = p.zx; z[1] = p.zy; z[2] = p.zz; z[3] = p.zw;
    col = p.colour;
    de = p.distance;
    for (int a = 0; a < 4; a++) begin
      prev[a] = z[a];
      st = int'(regs_shadow[REG_START_ITERS][a*8 +: 8]);
      lim = longint'($signed(regs_shadow[REG_FOLD_LIMITS][a*16 +: 16]));
      if (flags[FLAG_PROG] && flags[FLAG_AXIS+a] && it > st) begin
        kq = longint'(it - st) * 4096;
        den = longint'(regs_shadow[REG_SHRINK_RATES][a*16 +: 16]) + kq;
        ratio = (kq * 4096 + den / 2) / den;
        sc = longint'($signed(regs_shadow[REG_SHRINK_SCALES][a*16 +: 16]));
        lim = round_shift(lim * ratio * sc, 24);
      end
      lc[a] = lim * (64'sd1 <<< (FRAC_BITS - 12));
      if (!flags[FLAG_PROG] || flags[FLAG_AXIS+a])
        z[a] = clamp(mag(z[a] + lc[a]) - mag(z[a] - lc[a]) - z[a], COORD_BITS);
    end
    if (flags[FLAG_COLOUR]) begin
      for (int a = 0; a < 4; a++) begin
        f = longint'($signed(regs_shadow[REG_COLOUR_FACTORS][a*16 +: 16]));
        if (z[a] != prev[a]) begin
          if (flags[FLAG_WEIGHTED])
            col += round_shift(f * round_shift(mag(z[a]) - lc[a], FRAC_BITS - 16), 12);
          else
            col += f * 16;
        end
      end
      col = clamp(col, 32);
    end
    for (int m = 0; m < 5; m++) begin
      st = int'(regs_shadow[REG_START_ITERS][(m+1)*8 +: 8]);
      sp = int'(regs_shadow[REG_STOP_ITERS][m*8 +: 8]);
      if (flags[FLAG_MULT+m] && it >= st && it < sp) begin
        s = longint'($signed(regs_shadow[REG_MULT_SCALES][m*12 +: 12]));
        for (int a = 0; a < 4; a++) z[a] = clamp(round_shift(z[a] * s, 8), COORD_BITS);
        prod = (de * longint'(mag(s)) + 128) >> 8;
        de = (prod > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : prod;
      end
    end
    r.fx = z[0][COORD_BITS-1:0];
    r.fy = z[1][COORD_BITS-1:0];
    r.fz = z[2][COORD_BITS-1:0];
    r.fw = z[3][COORD_BITS-1:0];
    r.colour = col[31:0];
    r.distance = de[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: presents one pending item at a time and records the expectation on acceptance.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_folds.push_back(fold_point(in_flight));
      points_sent++;
    end
    if (!start || !busy) begin
      if (!rst && pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_flight = pending_points.pop_front();
        start <= 1'b1;
        z_x <= in_flight.zx; z_y <= in_flight.zy; z_z <= in_flight.zz; z_w <= in_flight.zw;
        iteration <= in_flight.iter;
        colour_in <= in_flight.colour;
        distance_in <= in_flight.distance;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    folded_t want;
    if (!rst && done) begin
      if (expected_folds.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_folds.pop_front();
        folds_checked++;
        if (fold_x !== want.fx) report_mismatch("fold_x", fold_x, want.fx);
        if (fold_y !== want.fy) report_mismatch("fold_y", fold_y, want.fy);
        if (fold_z !== want.fz) report_mismatch("fold_z", fold_z, want.fz);
        if (fold_w !== want.fw) report_mismatch("fold_w", fold_w, want.fw);
        if (colour_out !== want.colour) report_mismatch("colour_out", colour_out, want.colour);
        if (distance_out !== want.distance)
          report_mismatch("distance_out", distance_out, want.distance);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Stalled after %0d points sent and %0d results checked.",
               points_sent, folds_checked);
      $display("box_fold_4d_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    logic [63:0] mask;
    mask = (idx == REG_MODE_FLAGS) ? 64'hFFF : (idx == REG_START_ITERS) ? 64'hFFFF_FFFF_FFFF :
           (idx == REG_STOP_ITERS) ? 64'hFF_FFFF_FFFF :
           (idx == REG_MULT_SCALES) ? 64'h0FFF_FFFF_FFFF_FFFF : '1;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    regs_shadow[idx] = val & mask;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || start || expected_folds.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_q12();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(($urandom_range(0, 16'h2000)) + 16'h0400);
      3: return 16'(-$urandom_range(0, 16'h2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_mult();
    case ($urandom_range(5))
      0: return 12'h7FF;
      1: return 12'h800;
      2: return 12'h100;
      3: return 12'(-$urandom_range(12'h0C0, 12'h140));
      default: return 12'($urandom_range(12'h0C0, 12'h140));
    endcase
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(7))
      0: return {1'b0, {(COORD_BITS-1){1'b1}}};
      1: return {1'b1, {(COORD_BITS-1){1'b0}}};
      2, 3: return COORD_BITS'($urandom);
      default: return COORD_BITS'($urandom_range(0, 32'h0800_0000)) - (1 <<< 26);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.zx = pick_coord(); p.zy = pick_coord(); p.zz = pick_coord(); p.zw = pick_coord();
    p.iter = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 50));
    p.colour = ($urandom_range(3) == 0) ? 32'($urandom)
                                        : 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    p.distance = ($urandom_range(3) == 0) ? 32'($urandom)
                                          : 32'($urandom_range(0, 32'h0010_0000));
    return p;
  endfunction

  task automatic random_settings();
    logic [63:0] v;
    write_reg(REG_FOLD_LIMITS, {pick_q12(), pick_q12(), pick_q12(), pick_q12()});
    write_reg(REG_MODE_FLAGS, 64'($urandom));
    write_reg(REG_SHRINK_RATES, ($urandom_range(4) == 0) ? 64'h0 : {$urandom, $urandom});
    write_reg(REG_SHRINK_SCALES, {pick_q12(), pick_q12(), pick_q12(), pick_q12()});
    v = '0;
    for (int b = 0; b < 6; b++) v[b*8 +: 8] = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(0, 40));
    write_reg(REG_START_ITERS, v);
    v = '0;
    for (int b = 0; b < 5; b++) v[b*8 +: 8] = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(0, 60));
    write_reg(REG_STOP_ITERS, v);
    v = '0;
    for (int b = 0; b < 5; b++) v[b*12 +: 12] = pick_mult();
    write_reg(REG_MULT_SCALES, v);
    write_reg(REG_COLOUR_FACTORS, {pick_q12(), pick_q12(), pick_q12(), pick_q12()});
    settings_used++;
  endtask

  task automatic directed_points(int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p = random_point();
      case (i % 4)
        0: begin
          p.zx = {1'b0, {(COORD_BITS-1){1'b1}}}; p.zy = {1'b1, {(COORD_BITS-1){1'b0}}};
          p.zz = '0; p.zw = 1 <<< FRAC_BITS; p.iter = 8'hFF;
          p.colour = 32'h7FFF_FFFF; p.distance = 32'hFFFF_FFFF;
        end
        1: begin
          p.zx = 3 <<< FRAC_BITS; p.zy = -(3 <<< FRAC_BITS); p.zz = -(1 <<< FRAC_BITS);
          p.zw = 2 <<< (FRAC_BITS - 1); p.iter = 8'h00; p.colour = 32'h8000_0000;
          p.distance = '0;
        end
        default: ;
      endcase
      pending_points.push_back(p);
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    z_x = '0; z_y = '0; z_z = '0; z_w = '0; iteration = '0; colour_in = '0; distance_in = '0;
    errors = 0; points_sent = 0; folds_checked = 0; settings_used = 1; quiet_cycles = 0;
    sender_idle_pct = 17;
    regs_shadow[0] = 64'h1000_1000_1000_1000; regs_shadow[1] = '0; regs_shadow[2] = '0;
    regs_shadow[3] = 64'h1000_1000_1000_1000; regs_shadow[4] = '0; regs_shadow[5] = '0;
    regs_shadow[6] = 64'h0100_1001_0010_0100; regs_shadow[7] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed_points(8);
    drain();
    // Progressive shrink on every axis, weighted colour, all multipliers at the largest scale.
    write_reg(REG_MODE_FLAGS, 64'hFFF);
    write_reg(REG_SHRINK_RATES, 64'hFFFF_0001_2000_7FFF);
    write_reg(REG_SHRINK_SCALES, 64'h7FFF_8000_1800_F000);
    write_reg(REG_START_ITERS, 64'h00_00_00_05_00_00);
    write_reg(REG_STOP_ITERS, 64'hFF_FF_FF_FF_FF);
    write_reg(REG_MULT_SCALES, 64'h07FF_7FF7_FF7F_F7FF);
    write_reg(REG_COLOUR_FACTORS, 64'h7FFF_8000_1000_F000);
    settings_used++;
    directed_points(8);
    drain();
    // Zero rates, unweighted colour, negative extreme scale and empty windows.
    write_reg(REG_FOLD_LIMITS, 64'h7FFF_8000_0000_2000);
    write_reg(REG_MODE_FLAGS, 64'b1_1010_0011_1011);
    write_reg(REG_SHRINK_RATES, 64'h0);
    write_reg(REG_STOP_ITERS, 64'h10_00_FF_03_FF);
    write_reg(REG_MULT_SCALES, 64'h0800_8008_0080_0800);
    settings_used++;
    directed_points(8);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 17 : (ph < 8) ? 66 : 0;
      random_settings();
      for (int i = 0; i < 94; i++) pending_points.push_back(random_point());
      drain();
    end

    $display("Ran %0d points through %0d register settings, %0d results checked.",
             points_sent, settings_used, folds_checked);
    if (errors == 0 && expected_folds.size() == 0) begin
      $display("box_fold_4d_tb: clean");
    end else begin
      $display("box_fold_4d_tb: errors");
    end
    $finish;
  end

endmodule
